// ===== src/lmi_pkg.sv =====
// Shared types and constants for the linear motion interpolator.
// No dependencies.
package lmi_pkg;

    localparam int COORD_W    = 24;  // coordinate, 1/1024 mm
    localparam int DELTA_W    = 25;  // difference of two coordinates
    localparam int SPEED_W    = 16;  // Q2.14 speed factor
    localparam int CFG_W      = 16;
    localparam int SQ_W       = 50;  // sum of three squared deltas
    localparam int ROOT_W     = 25;  // isqrt of SQ_W bits
    localparam int SPEED_FRAC = 14;
    localparam int STEP_W     = 32;  // max_increment * speed_factor

    localparam logic [CFG_W-1:0] MAX_INC_RST   = 16'd1818;
    localparam logic [CFG_W-1:0] MIN_SPEED_RST = 16'd164;

    typedef enum logic [2:0] {
        STAT_POINT  = 3'd0,
        STAT_IDLE   = 3'd1,
        STAT_QUEUED = 3'd2,
        STAT_SLOW   = 3'd3,
        STAT_FULL   = 3'd4
    } t_status;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_TARGET = 1'b1
    } t_op;

    typedef enum logic {
        CFG_MAX_INC   = 1'b0,
        CFG_MIN_SPEED = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_target;

endpackage

// ===== src/linear_motion_interpolator.sv =====
// Linear motion interpolator top level: target queue, segment setup sequencer
// and point generator. Depends on lmi_pkg.
//
// Usage:
//  - Slave stream carries requests: tuser[0] = operation (0 tick, 1 target),
//    tdata = target x, y, z and speed factor. Master stream returns one result
//    per request: tuser = status, tdata = point x, y, z, tlast = last point.
//  - Config channel writes max_increment (index 0) and min_speed (index 1);
//    always ready, meant to be used only while the block is idle.
//  - Targets and ticks inside a running segment: result registered at the
//    accept edge, so a request can be taken every cycle while the receiver keeps up.
//  - A tick that opens a segment runs the setup sequencer: the delta, the shared
//    multiplier (three squares, step length), the square root, then restoring
//    division for the step count and for each of three offsets (quotient width
//    DW = max(FRACTION_BITS + 25, 39), 41 by default), and the point issue,
//    which waits while a result is still held for the receiver. A zero step
//    count skips the offsets.
//  - Not ready while setting up, or while a result waits on a stalled receiver.
//  - Reset returns to the origin with an empty queue and register defaults;
//    queue contents need no clearing.
module linear_motion_interpolator #(
    parameter int QUEUE_DEPTH     = 16,
    parameter int FRACTION_BITS   = 16,
    parameter int STEP_COUNT_BITS = 22
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // target_x, target_y, target_z, speed_factor
    input  logic [0:0]  s_axis_tuser,   // operation
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // point_x, point_y, point_z
    output logic [2:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast,   // last_point
    // config writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int F    = FRACTION_BITS;
    localparam int DW   = (F + lmi_pkg::DELTA_W > lmi_pkg::ROOT_W + lmi_pkg::SPEED_FRAC)
                        ? F + lmi_pkg::DELTA_W : lmi_pkg::ROOT_W + lmi_pkg::SPEED_FRAC;
    localparam int OFW  = F + lmi_pkg::DELTA_W + 1;   // position / offset width
    localparam int ITW  = $clog2(DW + 1);
    localparam int SCB  = STEP_COUNT_BITS;
    localparam int RW   = lmi_pkg::STEP_W + 1;        // divider remainder
    localparam int SRW  = lmi_pkg::ROOT_W + 3;        // sqrt remainder

    typedef enum logic [2:0] {
        S_IDLE, S_DELTA, S_SQ, S_SQRT, S_DIVC, S_DIVO, S_FIN
    } t_state;

    t_state r_state;

    // config
    logic [lmi_pkg::CFG_W-1:0] r_max_inc, r_min_speed;

    // queue
    lmi_pkg::t_target r_mem [QUEUE_DEPTH];
    lmi_pkg::t_target r_rd;
    logic [QW-1:0]    r_head;
    logic [CNTW-1:0]  r_qcount;

    // segment state
    logic signed [lmi_pkg::COORD_W-1:0] r_end [3];
    logic signed [OFW-1:0]              r_cur [3];
    logic signed [OFW-1:0]              r_off [3];
    logic signed [lmi_pkg::DELTA_W-1:0] r_d   [3];
    logic [SCB-1:0]                     r_steps;
    logic                               r_active;

    // shared units
    logic [ITW-1:0]                  r_cnt;
    logic [1:0]                      r_axis;
    logic [lmi_pkg::SQ_W-1:0]        r_prod, r_acc, r_rad;
    logic [lmi_pkg::STEP_W-1:0]      r_step, r_div;
    logic [lmi_pkg::ROOT_W-1:0]      r_root;
    logic [SRW-1:0]                  r_srem;
    logic [RW-1:0]                   r_rem;
    logic [DW-1:0]                   r_quo;

    // result register
    logic                          r_ov, r_last;
    logic [2:0]                    r_status;
    logic [lmi_pkg::COORD_W-1:0]   r_pt [3];

    // ---------------------------------------------------------------
    // combinational helpers
    logic in_acc, out_free;
    lmi_pkg::t_target in_tgt;
    assign in_tgt   = s_axis_tdata;
    assign out_free = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // tail slot of the queue
    logic [CNTW:0]  tail_sum;
    logic [QW-1:0]  tail;
    assign tail_sum = (CNTW + 1)'(r_head) + (CNTW + 1)'(r_qcount);
    assign tail = (tail_sum >= (CNTW + 1)'(QUEUE_DEPTH))
                ? QW'(tail_sum - (CNTW + 1)'(QUEUE_DEPTH)) : QW'(tail_sum);

    logic [QW-1:0] n_head;
    assign n_head = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // magnitudes of the deltas
    logic [lmi_pkg::DELTA_W-1:0] dmag [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            dmag[a] = r_d[a][lmi_pkg::DELTA_W-1] ? lmi_pkg::DELTA_W'(-r_d[a])
                                                 : lmi_pkg::DELTA_W'(r_d[a]);
        end
    end

    // shared multiplier
    logic [lmi_pkg::DELTA_W-1:0] mul_a, mul_b;
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    begin mul_a = dmag[0]; mul_b = dmag[0]; end
            2'd1:    begin mul_a = dmag[1]; mul_b = dmag[1]; end
            2'd2:    begin mul_a = dmag[2]; mul_b = dmag[2]; end
            default: begin
                mul_a = lmi_pkg::DELTA_W'(r_max_inc);
                mul_b = lmi_pkg::DELTA_W'(r_rd.speed);
            end
        endcase
    end

    // square root step
    logic [SRW-1:0] sq_t, sq_trial;
    logic           sq_ge;
    logic [lmi_pkg::ROOT_W-1:0] n_root;
    assign sq_t     = {r_srem[SRW-3:0], r_rad[lmi_pkg::SQ_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;
    assign n_root   = {r_root[lmi_pkg::ROOT_W-2:0], sq_ge};

    // restoring divider step
    logic [RW-1:0] dv_t;
    logic          dv_ge;
    logic [DW-1:0] n_quo;
    assign dv_t  = {r_rem[RW-2:0], r_quo[DW-1]};
    assign dv_ge = dv_t >= {1'b0, r_div};
    assign n_quo = {r_quo[DW-2:0], dv_ge};

    logic [SCB-1:0] n_count;
    assign n_count = (|n_quo[DW-1:SCB]) ? '1 : n_quo[SCB-1:0];

    // one point of the running segment
    logic signed [OFW-1:0] n_cur [3];
    always_comb begin
        for (int a = 0; a < 3; a++) n_cur[a] = r_cur[a] + r_off[a];
    end

    // ---------------------------------------------------------------
    // head entry is latched while idle and held through setup
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) r_rd <= r_mem[r_head];
        if (in_acc && s_axis_tuser[0] == lmi_pkg::OP_TARGET
            && in_tgt.speed >= r_min_speed && r_qcount < CNTW'(QUEUE_DEPTH)) begin
            r_mem[tail] <= in_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_inc   <= lmi_pkg::MAX_INC_RST;
            r_min_speed <= lmi_pkg::MIN_SPEED_RST;
            r_head      <= '0;
            r_qcount    <= '0;
            r_active    <= 1'b0;
            r_steps     <= '0;
            r_ov        <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_end[a] <= '0;
                r_cur[a] <= '0;
                r_off[a] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == lmi_pkg::CFG_MAX_INC) r_max_inc <= i_cfg_data;
                else                                     r_min_speed <= i_cfg_data;
            end
            if (m_axis_tready) r_ov <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ov <= 1'b1;
                        r_last <= 1'b0;
                        for (int a = 0; a < 3; a++) r_pt[a] <= '0;
                        if (s_axis_tuser[0] == lmi_pkg::OP_TARGET) begin
                            if (in_tgt.speed < r_min_speed) begin
                                r_status <= lmi_pkg::STAT_SLOW;
                            end else if (r_qcount >= CNTW'(QUEUE_DEPTH)) begin
                                r_status <= lmi_pkg::STAT_FULL;
                            end else begin
                                r_qcount <= r_qcount + 1'b1;
                                r_status <= lmi_pkg::STAT_QUEUED;
                            end
                        end else if (r_active) begin
                            r_status <= lmi_pkg::STAT_POINT;
                            if (r_steps != '0) begin
                                r_steps <= r_steps - 1'b1;
                                for (int a = 0; a < 3; a++) begin
                                    r_cur[a] <= n_cur[a];
                                    r_pt[a]  <= n_cur[a][F +: lmi_pkg::COORD_W];
                                end
                            end else begin
                                for (int a = 0; a < 3; a++) r_pt[a] <= r_end[a];
                                r_last   <= 1'b1;
                                r_active <= 1'b0;
                            end
                        end else if (r_qcount != '0) begin
                            // segment opens; result comes out of the sequencer
                            r_ov     <= 1'b0;
                            r_head   <= n_head;
                            r_qcount <= r_qcount - 1'b1;
                            r_state  <= S_DELTA;
                        end else begin
                            r_status <= lmi_pkg::STAT_IDLE;
                        end
                    end
                end
                S_DELTA: begin
                    r_d[0] <= lmi_pkg::DELTA_W'($signed(r_rd.x)) - lmi_pkg::DELTA_W'(r_end[0]);
                    r_d[1] <= lmi_pkg::DELTA_W'($signed(r_rd.y)) - lmi_pkg::DELTA_W'(r_end[1]);
                    r_d[2] <= lmi_pkg::DELTA_W'($signed(r_rd.z)) - lmi_pkg::DELTA_W'(r_end[2]);
                    for (int a = 0; a < 3; a++) begin
                        r_cur[a] <= OFW'(r_end[a]) <<< F;
                    end
                    r_end[0] <= r_rd.x;
                    r_end[1] <= r_rd.y;
                    r_end[2] <= r_rd.z;
                    r_active <= 1'b1;
                    r_acc    <= '0;
                    r_cnt    <= '0;
                    r_state  <= S_SQ;
                end
                S_SQ: begin
                    r_prod <= lmi_pkg::SQ_W'(mul_a * mul_b);
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt >= ITW'(1) && r_cnt <= ITW'(3)) r_acc <= r_acc + r_prod;
                    if (r_cnt == ITW'(4)) begin
                        r_step  <= r_prod[lmi_pkg::STEP_W-1:0];
                        r_rad   <= r_acc;
                        r_root  <= '0;
                        r_srem  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_srem <= sq_ge ? sq_t - sq_trial : sq_t;
                    r_root <= n_root;
                    r_rad  <= r_rad << 2;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == ITW'(lmi_pkg::ROOT_W - 1)) begin
                        r_quo   <= DW'({n_root, lmi_pkg::SPEED_FRAC'(0)});
                        r_div   <= r_step;  // zero divisor gives all ones
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIVC;
                    end
                end
                S_DIVC, S_DIVO: begin
                    r_rem <= dv_ge ? dv_t - {1'b0, r_div} : dv_t;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ITW'(DW - 1)) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        if (r_state == S_DIVC) begin
                            r_steps <= n_count;
                            r_div   <= lmi_pkg::STEP_W'(n_count);
                            r_axis  <= 2'd0;
                            r_quo   <= DW'({dmag[0], F'(0)});
                            if (n_count == '0) begin
                                for (int a = 0; a < 3; a++) r_off[a] <= '0;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_DIVO;
                            end
                        end else begin
                            r_off[r_axis] <= r_d[r_axis][lmi_pkg::DELTA_W-1]
                                           ? -OFW'(n_quo) : OFW'(n_quo);
                            if (r_axis == 2'd2) begin
                                r_state <= S_FIN;
                            end else begin
                                r_axis <= r_axis + 1'b1;
                                r_quo  <= DW'({dmag[r_axis + 1'b1], F'(0)});
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_status <= lmi_pkg::STAT_POINT;
                        r_state  <= S_IDLE;
                        if (r_steps != '0) begin
                            r_last  <= 1'b0;
                            r_steps <= r_steps - 1'b1;
                            for (int a = 0; a < 3; a++) begin
                                r_cur[a] <= n_cur[a];
                                r_pt[a]  <= n_cur[a][F +: lmi_pkg::COORD_W];
                            end
                        end else begin
                            for (int a = 0; a < 3; a++) r_pt[a] <= r_end[a];
                            r_last   <= 1'b1;
                            r_active <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_status;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {r_pt[2], r_pt[1], r_pt[0]};

`ifndef SYNTH
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("ready during segment setup");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcount <= CNTW'(QUEUE_DEPTH))
        else $error("queue count past depth");
    a_steps_need_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_steps != '0) |-> r_active)
        else $error("steps left on an idle segment");
    a_queue_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser[0] == lmi_pkg::OP_TARGET && in_tgt.speed >= r_min_speed
         && r_qcount < CNTW'(QUEUE_DEPTH)) |=> (r_qcount == $past(r_qcount) + 1'b1))
        else $error("queued target not counted");
`endif

endmodule

// ===== tb/linear_motion_interpolator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for linear_motion_interpolator: stream driver, result
// monitor and a cycle-accurate-free point predictor. Depends on lmi_pkg and the RTL.
module linear_motion_interpolator_tb;

    localparam int        Q_DEPTH   = 16;
    localparam int        FRAC      = 16;
    localparam longint    CNT_MAX   = (64'sd1 <<< 22) - 1;
    localparam int        SETTLE    = 300;      // longer than a segment setup
    localparam longint    LIMIT     = 1500000;

    typedef struct {
        lmi_pkg::t_op op;
        logic [23:0]  x, y, z;
        logic [15:0]  spd;
    } t_req;

    typedef struct {
        lmi_pkg::t_status status;
        logic [23:0]      x, y, z;
        logic             last;
    } t_point;

    typedef struct {
        longint x, y, z, spd;
    } t_wait_tgt;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;   // x, y, z, speed from bit 0 up
    logic [0:0]  s_axis_tuser = '0;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // x, y, z from bit 0 up
    logic [2:0]  m_axis_tuser;        // status
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    linear_motion_interpolator dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    longint    pr_max_inc = 1818, pr_min_spd = 164;
    longint    end_x, end_y, end_z, cur_x, cur_y, cur_z, off_x, off_y, off_z, steps_left;
    bit        seg_on;
    t_wait_tgt tgt_q[$];

    t_req   req_q[$];
    t_point point_q[$];
    int     errors = 0;
    int     n_stat[5];
    longint cycles = 0;
    bit     req_taken, res_taken;
    bit     no_idle = 0;
    bit     hold_go = 0;
    int     hold_left = 0;
    int     tx_gap = 0, rx_wait = 0;
    int     n_cfg = 0;

    // generator view of the segment chain
    longint gen_x = 0, gen_y = 0, gen_z = 0;

    function automatic longint root_floor(longint v);
        longint res = 0, bit_v = 64'sd1 <<< 60;
        while (bit_v > v) bit_v = bit_v >>> 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v   = v - (res + bit_v);
                res = (res >>> 1) + bit_v;
            end else begin
                res = res >>> 1;
            end
            bit_v = bit_v >>> 2;
        end
        return res;
    endfunction

    function automatic void open_segment();
        t_wait_tgt t = tgt_q.pop_front();
        longint dx = t.x - end_x, dy = t.y - end_y, dz = t.z - end_z;
        longint span = root_floor(dx * dx + dy * dy + dz * dz);
        longint stp = pr_max_inc * t.spd;
        longint cnt;
        if (stp == 0) cnt = CNT_MAX;
        else begin
            cnt = (span <<< 14) / stp;
            if (cnt > CNT_MAX) cnt = CNT_MAX;
        end
        cur_x = end_x * 65536; cur_y = end_y * 65536; cur_z = end_z * 65536;
        off_x = cnt ? (dx * 65536) / cnt : 0;
        off_y = cnt ? (dy * 65536) / cnt : 0;
        off_z = cnt ? (dz * 65536) / cnt : 0;
        steps_left = cnt;
        end_x = t.x; end_y = t.y; end_z = t.z;
        seg_on = 1;
    endfunction

    function automatic t_point next_point(t_req r);
        t_point    p = '{lmi_pkg::STAT_IDLE, '0, '0, '0, 1'b0};
        t_wait_tgt t;
        if (r.op == lmi_pkg::OP_TARGET) begin
            if (r.spd < pr_min_spd) p.status = lmi_pkg::STAT_SLOW;
            else if (tgt_q.size() >= Q_DEPTH) p.status = lmi_pkg::STAT_FULL;
            else begin
                t.x = longint'($signed(r.x)); t.y = longint'($signed(r.y));
                t.z = longint'($signed(r.z)); t.spd = r.spd;
                tgt_q.insert(tgt_q.size(), t);
                p.status = lmi_pkg::STAT_QUEUED;
            end
        end else begin
            if (!seg_on && tgt_q.size() > 0) open_segment();
            if (seg_on) begin
                p.status = lmi_pkg::STAT_POINT;
                if (steps_left > 0) begin
                    cur_x += off_x; cur_y += off_y; cur_z += off_z;
                    steps_left--;
                    p.x = 24'(cur_x >>> FRAC);
                    p.y = 24'(cur_y >>> FRAC);
                    p.z = 24'(cur_z >>> FRAC);
                end else begin
                    p.x = 24'(end_x); p.y = 24'(end_y); p.z = 24'(end_z);
                    p.last = 1'b1;
                    seg_on = 0;
                end
            end
        end
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH %s: got %0h, want %0h at cycle %0d", what, got, want, cycles);
    endtask

    // Monitor: both accepts are sampled at the rising edge.
    always @(posedge i_clk) begin
        t_point want;
        cycles++;
        req_taken = s_axis_tvalid && s_axis_tready && i_rst_n;
        res_taken = m_axis_tvalid && m_axis_tready && i_rst_n;
        if (i_cfg_valid && o_cfg_ready && i_rst_n) begin
            if (i_cfg_index == lmi_pkg::CFG_MAX_INC) pr_max_inc = i_cfg_data;
            else pr_min_spd = i_cfg_data;
        end
        if (req_taken)
            point_q.insert(point_q.size(),
                next_point('{lmi_pkg::t_op'(s_axis_tuser[0]), s_axis_tdata[23:0],
                s_axis_tdata[47:24], s_axis_tdata[71:48], s_axis_tdata[87:72]}));
        if (res_taken) begin
            if (point_q.size() == 0) report_mismatch("unexpected result", m_axis_tuser, 0);
            else begin
                want = point_q.pop_front();
                if (m_axis_tuser < 5) n_stat[m_axis_tuser]++;
                if (m_axis_tuser != want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tdata[23:0] != want.x)
                    report_mismatch("point_x", m_axis_tdata[23:0], want.x);
                if (m_axis_tdata[47:24] != want.y)
                    report_mismatch("point_y", m_axis_tdata[47:24], want.y);
                if (m_axis_tdata[71:48] != want.z)
                    report_mismatch("point_z", m_axis_tdata[71:48], want.z);
                if (m_axis_tlast != want.last)
                    report_mismatch("last_point", m_axis_tlast, want.last);
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("linear_motion_interpolator_tb NOT OK");
            $finish;
        end
    end

    // Request driver: one update of tvalid per falling edge.
    always @(negedge i_clk) begin
        bit   v;
        t_req r;
        v = s_axis_tvalid;
        if (v && req_taken) begin
            v = 0;
            tx_gap = no_idle ? 0 : $urandom_range(0, 11);
        end
        if (!v && i_rst_n) begin
            if (tx_gap > 0) tx_gap--;
            else if (req_q.size() > 0) begin
                r = req_q.pop_front();
                s_axis_tuser <= r.op;
                s_axis_tdata <= {r.spd, r.z, r.y, r.x};
                v = 1;
            end
        end
        s_axis_tvalid <= v;
    end

    // Result receiver, with an optional long hold-off.
    always @(negedge i_clk) begin
        if (hold_go) begin
            hold_left = 400;
            hold_go   = 0;
        end
        if (res_taken) rx_wait = no_idle ? 0 : $urandom_range(0, 11);
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n;
        end
    end

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    task automatic push_target(longint x, longint y, longint z, longint spd);
        req_q.insert(req_q.size(), '{lmi_pkg::OP_TARGET, 24'(x), 24'(y), 24'(z), 16'(spd)});
        if (spd >= pr_min_spd) begin
            gen_x = x; gen_y = y; gen_z = z;
        end
    endtask

    task automatic push_ticks(int n);
        repeat (n) req_q.insert(req_q.size(), '{lmi_pkg::OP_TICK, 24'($urandom),
                                24'($urandom), 24'($urandom), 16'($urandom)});
    endtask

    task automatic wait_idle();
        while (req_q.size() != 0 || s_axis_tvalid || point_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(lmi_pkg::t_cfg_idx idx, longint val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 16'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // Mostly well-formed segments sized to the current step length, some noise.
    task automatic random_phase(int n_items);
        int     sent = 0;
        longint su, rng, spd;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                push_ticks(1);          // stray tick, often on an idle block
                sent++;
            end else begin
                if ($urandom_range(0, 7) == 0)
                    spd = $urandom_range(0, 65535);      // may well be refused
                else
                    spd = $urandom_range((pr_min_spd > 0) ? pr_min_spd : 1, 65535);
                su  = (pr_max_inc * spd) >>> 14;
                rng = ((su > 0) ? su : 1) * 6;
                push_target(clamp24(gen_x + $signed($urandom_range(0, 2 * rng)) - rng),
                            clamp24(gen_y + $signed($urandom_range(0, 2 * rng)) - rng),
                            clamp24(gen_z + $signed($urandom_range(0, 2 * rng)) - rng), spd);
                push_ticks($urandom_range(1, 16));
                sent += 9;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset register values: idle tick, too slow, zero step count,
        // a short segment, then a full queue.
        push_ticks(1);
        push_target(100, 100, 100, 163);
        push_target(100, 100, 100, 0);
        push_target(0, 0, 0, 16384);
        push_ticks(2);
        push_target(-5000, 3000, 7000, 65535);
        push_ticks(6);
        hold_go = 1;                    // receiver stalls, block backs up
        repeat (17) push_target(-5000, 3000, 7000, 16384);
        push_ticks(18);
        random_phase(70);
        wait_idle();

        // Largest step, no speed floor: corner to corner across the full range.
        write_reg(lmi_pkg::CFG_MAX_INC, 65535);
        write_reg(lmi_pkg::CFG_MIN_SPEED, 0);
        push_target(8388607, -8388608, 8388607, 65535);
        push_target(-8388608, 8388607, -8388608, 65535);
        push_ticks(175);
        random_phase(40);
        wait_idle();

        // Smallest step: only the top speed passes.
        no_idle = 1;
        write_reg(lmi_pkg::CFG_MAX_INC, 1);
        write_reg(lmi_pkg::CFG_MIN_SPEED, 65535);
        random_phase(40);
        wait_idle();

        no_idle = 0;
        write_reg(lmi_pkg::CFG_MAX_INC, 3000);
        write_reg(lmi_pkg::CFG_MIN_SPEED, 8000);
        random_phase(70);
        wait_idle();

        $display("covered %0d points, %0d idle ticks, %0d queued, %0d slow, %0d full",
                 n_stat[0], n_stat[1], n_stat[2], n_stat[3], n_stat[4]);
        $display("%0d register writes, %0d mismatches, %0d cycles", n_cfg, errors, cycles);
        if (errors == 0) begin
            $display("linear_motion_interpolator_tb OK");
        end else begin
            $display("linear_motion_interpolator_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/lmi_pkg.sv
src/linear_motion_interpolator.sv
tb/linear_motion_interpolator_tb.sv
